/* design/svw_pkg.sv */
// Shared types, widths and helpers for the sorted vertex welder.
// Used by every module of the block; depends on nothing else.
package svw_pkg;

   localparam int COORD_W     = 32;
   localparam int TOL_W       = 63;
   localparam int WIN_W       = 31;
   localparam int COUNT_W     = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int SQ_W        = 2 * COORD_W;
   localparam int DIST_W      = SQ_W + 2;

   localparam int WINDOW_DEPTH_DEFAULT = 16;
   localparam int MAX_VERTICES_DEFAULT = 65536;
   localparam int COUNT_CEILING        = 131071;

   localparam logic [TOL_W-1:0] TOL_RESET = 63'd429497;
   localparam logic [WIN_W-1:0] WIN_RESET = 31'd655;

   localparam logic [CSR_INDEX_W-1:0] CSR_WELD_TOLERANCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_WINDOW       = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_SUM,
      ST_CMP,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } vertex_type;

   // Travels down the row of cells, newest kept vertex first.
   typedef struct packed {
      logic       scanning;
      logic       hit;
      vertex_type vtx;
   } scan_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   // Magnitude of the difference of two signed coordinates; fits in COORD_W bits.
   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      logic [COORD_W:0] n;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      n = -d;
      return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
   endfunction

endpackage

/* design/sorted_vertex_weld_core.sv */
// Streaming vertex welder for x-sorted Q16.16 vertices. Each accepted word
// passes the states DIFF, MUL, SUM, CMP and DECIDE, following the
// four-stage squared-distance pipeline (difference, square, sum, compare)
// in every window cell plus a decision state; its result is then registered
// and only then is the next word taken. DECIDE waits while an untaken result
// fills the output register; a finished result waits there while the next
// word is already being worked on. Depends on svw_pkg, svw_cell and svw_dist.
module sorted_vertex_weld_core #(
   parameter int WINDOW_DEPTH = svw_pkg::WINDOW_DEPTH_DEFAULT,
   parameter int MAX_VERTICES = svw_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [svw_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [svw_pkg::COORD_W-1:0] req_pos_y,
   input  logic signed [svw_pkg::COORD_W-1:0] req_pos_z,
   input  logic                            req_last_vertex,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_keep,
   output logic signed [svw_pkg::COORD_W-1:0] rsp_out_x,
   output logic signed [svw_pkg::COORD_W-1:0] rsp_out_y,
   output logic signed [svw_pkg::COORD_W-1:0] rsp_out_z,
   output logic [svw_pkg::COUNT_W-1:0]     rsp_unique_count,
   output logic                            rsp_last_result,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [svw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [svw_pkg::TOL_W-1:0]       csr_wdata
);
   import svw_pkg::*;

   localparam int CountLimitInt = (MAX_VERTICES < COUNT_CEILING) ? MAX_VERTICES : COUNT_CEILING;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(CountLimitInt);

   state_type          state_ff;
   state_type          state_in;
   logic [TOL_W-1:0]   tol_ff;
   logic [TOL_W-1:0]   tol_in;
   logic [WIN_W-1:0]   win_ff;
   logic [WIN_W-1:0]   win_in;
   vertex_type         query_ff;
   vertex_type         query_in;
   logic               last_ff;
   logic               last_in;
   logic               skip_ff;
   logic               skip_in;
   vertex_type         match_ff;
   vertex_type         match_in;
   logic [COUNT_W-1:0] total_ff;
   logic [COUNT_W-1:0] total_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               keep_ff;
   logic               keep_in;
   vertex_type         out_ff;
   vertex_type         out_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               rlast_ff;
   logic               rlast_in;

   logic               accept;
   logic               fire;
   logic               match_near;
   logic               skip_hold;
   logic               keep;
   logic [COUNT_W-1:0] count_new;
   cell_ctrl_type      ctrl;

   vertex_type vtx_chain   [WINDOW_DEPTH+1];
   logic       valid_chain [WINDOW_DEPTH+1];
   scan_type   scan_chain  [WINDOW_DEPTH+1];

   // distance to the active match point, for the weld-skip run
   svw_dist u_match_dist (
      .clock     (clock),
      .a_vtx     (match_ff),
      .b_vtx     (query_ff),
      .tolerance (tol_ff),
      .near      (match_near)
   );

   assign vtx_chain[0]   = query_ff;
   assign valid_chain[0] = 1'b1;
   assign scan_chain[0]  = '{scanning: 1'b1, hit: 1'b0, vtx: '0};

   genvar gi;
   generate
      for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
         svw_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .query      (query_ff),
            .tolerance  (tol_ff),
            .window     (win_ff),
            .prev_vtx   (vtx_chain[gi]),
            .prev_valid (valid_chain[gi]),
            .vtx_out    (vtx_chain[gi+1]),
            .valid_out  (valid_chain[gi+1]),
            .scan_in    (scan_chain[gi]),
            .scan_out   (scan_chain[gi+1])
         );
      end
   endgenerate

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_MUL;
         ST_MUL:    state_in = ST_SUM;
         ST_SUM:    state_in = ST_CMP;
         ST_CMP:    state_in = ST_DECIDE;
         ST_DECIDE: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      fire      = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_DECIDE: fire      = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            fire      = 1'b0;
         end
      endcase
   end

   assign accept    = req_valid & req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      tol_in = tol_ff;
      win_in = win_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WELD_TOLERANCE: tol_in = csr_wdata;
            CSR_X_WINDOW:       win_in = csr_wdata[WIN_W-1:0];
            default: begin
               tol_in = tol_ff;
               win_in = win_ff;
            end
         endcase
      end
   end

   always_comb begin
      query_in = accept ? '{x: req_pos_x, y: req_pos_y, z: req_pos_z} : query_ff;
      last_in  = accept ? req_last_vertex : last_ff;

      skip_hold = skip_ff & match_near;
      keep      = ~skip_hold & ~scan_chain[WINDOW_DEPTH].hit;
      count_new = (keep && total_ff < COUNT_LIMIT) ? total_ff + 1'b1 : total_ff;

      ctrl.shift = fire & keep;
      ctrl.clear = fire & last_ff;

      skip_in  = skip_ff;
      match_in = match_ff;
      total_in = total_ff;
      if (fire) begin
         skip_in  = (skip_hold | scan_chain[WINDOW_DEPTH].hit) & ~last_ff;
         total_in = last_ff ? '0 : count_new;
         if (!skip_hold && scan_chain[WINDOW_DEPTH].hit) begin
            match_in = scan_chain[WINDOW_DEPTH].vtx;
         end
      end

      // hold the result until taken
      rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      keep_in  = fire ? keep : keep_ff;
      out_in   = fire ? query_ff : out_ff;
      count_in = fire ? count_new : count_ff;
      rlast_in = fire ? last_ff : rlast_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tol_ff       <= TOL_RESET;
         win_ff       <= WIN_RESET;
         skip_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tol_ff       <= tol_in;
         win_ff       <= win_in;
         skip_ff      <= skip_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff <= query_in;
      last_ff  <= last_in;
      match_ff <= match_in;
      keep_ff  <= keep_in;
      out_ff   <= out_in;
      count_ff <= count_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_keep         = keep_ff;
   assign rsp_out_x        = out_ff.x;
   assign rsp_out_y        = out_ff.y;
   assign rsp_out_z        = out_ff.z;
   assign rsp_unique_count = count_ff;
   assign rsp_last_result  = rlast_ff;

endmodule

/* design/svw_dist.sv */
// Pipelined squared-distance unit: difference, square, sum, compare.
// Depends on svw_pkg. The result is registered after each of the four steps.
module svw_dist (
   input  logic                     clock,
   input  svw_pkg::vertex_type      a_vtx,
   input  svw_pkg::vertex_type      b_vtx,
   input  logic [svw_pkg::TOL_W-1:0] tolerance,
   output logic                     near
);
   import svw_pkg::*;

   logic [COORD_W-1:0] mag_in [3];
   logic [COORD_W-1:0] mag_ff [3];
   logic [SQ_W-1:0]    sq_in  [3];
   logic [SQ_W-1:0]    sq_ff  [3];
   logic [DIST_W-1:0]  sum_in;
   logic [DIST_W-1:0]  sum_ff;
   logic               near_in;
   logic               near_ff;

   always_comb begin
      mag_in[0] = abs_diff(a_vtx.x, b_vtx.x);
      mag_in[1] = abs_diff(a_vtx.y, b_vtx.y);
      mag_in[2] = abs_diff(a_vtx.z, b_vtx.z);
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = SQ_W'({{COORD_W{1'b0}}, mag_ff[k]} * {{COORD_W{1'b0}}, mag_ff[k]});
      end
      sum_in = DIST_W'(sq_ff[0]) + DIST_W'(sq_ff[1]) + DIST_W'(sq_ff[2]);
      // tolerance stays below the 64-bit ceiling, so the unsaturated sum compares the same
      near_in = sum_ff < DIST_W'(tolerance);
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      sq_ff   <= sq_in;
      sum_ff  <= sum_in;
      near_ff <= near_in;
   end

   assign near = near_ff;

endmodule

/* design/svw_cell.sv */
// One window cell: holds a kept vertex, tests it against the current word
// and passes scan state and its vertex on to the next cell. Depends on svw_pkg, svw_dist.
module svw_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  svw_pkg::cell_ctrl_type    ctrl,
   input  svw_pkg::vertex_type       query,
   input  logic [svw_pkg::TOL_W-1:0] tolerance,
   input  logic [svw_pkg::WIN_W-1:0] window,
   input  svw_pkg::vertex_type       prev_vtx,
   input  logic                      prev_valid,
   output svw_pkg::vertex_type       vtx_out,
   output logic                      valid_out,
   input  svw_pkg::scan_type         scan_in,
   output svw_pkg::scan_type         scan_out
);
   import svw_pkg::*;

   vertex_type vtx_ff;
   vertex_type vtx_in;
   logic       valid_ff;
   logic       valid_in;
   logic       below_ff;
   logic       below_in;
   logic       near;
   logic       live;
   logic       hit_here;
   logic signed [COORD_W+1:0] thr;
   logic signed [COORD_W+1:0] own_x;

   svw_dist u_dist (
      .clock     (clock),
      .a_vtx     (vtx_ff),
      .b_vtx     (query),
      .tolerance (tolerance),
      .near      (near)
   );

   always_comb begin
      thr      = $signed({{2{query.x[COORD_W-1]}}, query.x}) - $signed({3'b0, window});
      own_x    = $signed({{2{vtx_ff.x[COORD_W-1]}}, vtx_ff.x});
      below_in = own_x < thr;

      vtx_in   = ctrl.shift ? prev_vtx : vtx_ff;
      valid_in = ctrl.clear ? 1'b0 : (ctrl.shift ? prev_valid : valid_ff);

      // a cell that is empty or too far behind ends the scan
      live              = scan_in.scanning & valid_ff & ~below_ff;
      hit_here          = live & near;
      scan_out.scanning = live & ~near;
      scan_out.hit      = scan_in.hit | hit_here;
      scan_out.vtx      = hit_here ? vtx_ff : scan_in.vtx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vtx_ff   <= vtx_in;
      below_ff <= below_in;
   end

   assign vtx_out   = vtx_ff;
   assign valid_out = valid_ff;

endmodule

/* design/svw_checker.sv */
// Port-level checks for sorted_vertex_weld_core, attached by bind below.
// Depends on svw_pkg and the top level's port list.
module svw_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [svw_pkg::COORD_W-1:0]     req_pos_x,
   input logic [svw_pkg::COORD_W-1:0]     req_pos_y,
   input logic [svw_pkg::COORD_W-1:0]     req_pos_z,
   input logic                            req_last_vertex,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_keep,
   input logic [svw_pkg::COORD_W-1:0]     rsp_out_x,
   input logic [svw_pkg::COORD_W-1:0]     rsp_out_y,
   input logic [svw_pkg::COORD_W-1:0]     rsp_out_z,
   input logic [svw_pkg::COUNT_W-1:0]     rsp_unique_count,
   input logic                            rsp_last_result,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [svw_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [svw_pkg::TOL_W-1:0]       csr_wdata
);
   import svw_pkg::*;

   // one word in flight: no second accept straight after the first
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("word accepted while another is in flight");

   // a result never appears in the cycle right after an accept
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result offered too early");

   // a kept vertex is always counted
   a_kept_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_keep |-> rsp_unique_count != '0)
      else $error("kept vertex with zero unique count");

   // stalled result holds: valid, keep, x and unique count stay stable
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_keep)
         && $stable(rsp_out_x) && $stable(rsp_unique_count))
      else $error("stalled result changed");

endmodule

bind sorted_vertex_weld_core svw_checker u_svw_checker (.*);
